/* sv/ssbd_pkg.sv */
// ----------------------------------------------------------------------------
// ssbd_pkg
// Shared constants, types and helper functions for the shifted box-filter
// downsampler.
// ----------------------------------------------------------------------------
package ssbd_pkg;

   localparam int MaxWidth   = 1024;
   localparam int MaxHeight  = 1024;
   localparam int MaxFactor  = 8;
   localparam int StoreRows  = MaxFactor + 4;
   localparam int NumChan    = 3;

   localparam int ColBits    = $clog2(MaxWidth);
   localparam int HgtBits    = $clog2(MaxHeight);
   localparam int RowBits    = $clog2(StoreRows);
   localparam int StoreDepth = StoreRows * MaxWidth;
   localparam int AddrBits   = RowBits + ColBits;
   localparam int SizeBits   = 11;
   localparam int FactorBits = $clog2(MaxFactor + 1);
   localparam int FsqBits    = 2 * FactorBits;
   localparam int PosBits    = SizeBits + FactorBits;
   localparam int IBits      = PosBits + 1;
   localparam int WeightBits = 17;
   localparam int ProdBits   = WeightBits + 8;
   localparam int AccBits    = 8 + 16 + FsqBits;
   localparam int RemBits    = AccBits + 1;
   localparam int DivBits    = SizeBits;

   localparam int RecipShift   = DivBits + $clog2(MaxFactor) + 2;
   localparam int RecipBits    = RecipShift + 1;
   localparam int RowShift     = SizeBits + RowBits + 2;
   localparam int RowRecip     = (2 ** RowShift + StoreRows - 1) / StoreRows;
   localparam int RowRecipBits = RowShift + 1;

   typedef enum logic [2:0] {
      CSR_WIDTH,
      CSR_HEIGHT,
      CSR_FACTOR,
      CSR_SHIFT_X_WHOLE,
      CSR_SHIFT_X_FRAC,
      CSR_SHIFT_Y_WHOLE,
      CSR_SHIFT_Y_FRAC
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TRIG1,
      ST_TRIG2,
      ST_BSETUP,
      ST_BCHECK,
      ST_WINDOW,
      ST_DRAIN,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic       prod_en;
      logic       acc_en;
      logic       acc_clr;
      logic       div_load;
      logic       div_step;
      logic [2:0] div_bit;
   } lane_ctrl_type;

   typedef struct packed {
      logic                valid;
      logic [SizeBits-1:0] lo;
      logic [SizeBits-1:0] hi;
   } range_type;

   typedef logic [RecipBits-1:0] recip_arr_type [MaxFactor+1];

   // ceil(2^RecipShift / k) for k = 1 .. MaxFactor
   localparam recip_arr_type FRecip = '{
      '0,
      RecipBits'((2 ** RecipShift) / 1),
      RecipBits'((2 ** RecipShift + 1) / 2),
      RecipBits'((2 ** RecipShift + 2) / 3),
      RecipBits'((2 ** RecipShift + 3) / 4),
      RecipBits'((2 ** RecipShift + 4) / 5),
      RecipBits'((2 ** RecipShift + 5) / 6),
      RecipBits'((2 ** RecipShift + 6) / 7),
      RecipBits'((2 ** RecipShift + 7) / 8)
   };

   // floor(x / f) by reciprocal, exact over the operand range
   function automatic logic [DivBits-1:0] div_factor(input logic [DivBits-1:0] x,
                                                     input logic [FactorBits-1:0] f);
      logic [DivBits+RecipBits-1:0] p;
      p = (DivBits+RecipBits)'(x) * (DivBits+RecipBits)'(FRecip[f]);
      return p[RecipShift +: DivBits];
   endfunction

   // x mod StoreRows by reciprocal
   function automatic logic [RowBits-1:0] mod_rows(input logic [SizeBits-1:0] x);
      logic [SizeBits+RowRecipBits-1:0] p;
      logic [SizeBits-1:0]              q;
      logic [SizeBits-1:0]              r;
      p = (SizeBits+RowRecipBits)'(x) * (SizeBits+RowRecipBits)'(RowRecip);
      q = p[RowShift +: SizeBits];
      r = x - SizeBits'(q * SizeBits'(StoreRows));
      return r[RowBits-1:0];
   endfunction

endpackage

/* sv/subpixel_shift_box_downsample_core.sv */
// ----------------------------------------------------------------------------
// subpixel_shift_box_downsample_core
// Box-filter downsampler with a global bilinear sub-pixel shift, three lanes.
// ----------------------------------------------------------------------------
// Source pixels enter on req_* in raster order, one item per pixel; req_stall
// is high while an item is being worked on. Each item is written to a line
// store of StoreRows rows. When it completes one or more blocks, each block
// is produced on rsp_*, in row then column order, run_last marking the last
// block of that item. Three channel lanes accumulate the weighted window in
// parallel and divide their sums; a merge stage loads the output register.
// Each block inside the margin makes one line store read per window pixel,
// then runs the 8-step divider; a block in the margin skips both and is
// produced as zeros.
// The output register holds a result while rsp_stall is high; the block
// waits for it to be taken before loading the next one, and accepts the next
// item once the last result of the current one is loaded.
// Registers must be written on csr_* only while idle; the block itself does
// not enforce this. Reset clears the position and loads the register
// defaults; the line store is not cleared, and rows are valid once written.
// ----------------------------------------------------------------------------
module subpixel_shift_box_downsample_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_chan0,
   input  logic [7:0]  req_chan1,
   input  logic [7:0]  req_chan2,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out0,
   output logic [7:0]  rsp_out1,
   output logic [7:0]  rsp_out2,
   output logic [9:0]  rsp_block_col,
   output logic [9:0]  rsp_block_row,
   output logic        rsp_run_last,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [10:0] csr_data
);
   import ssbd_pkg::*;

   // configuration
   logic [10:0] width_ff, height_ff;
   logic [3:0]  factor_ff;
   logic [1:0]  sxw_ff, syw_ff;
   logic [7:0]  sxf_ff, syf_ff;

   logic [SizeBits-1:0]   w_sat, h_sat;
   logic [FactorBits-1:0] f_sat;
   logic [SizeBits-1:0]   nbc_ff, nbr_ff;
   logic [FsqBits-1:0]    fsq_ff;

   // control
   state_type            state_ff, state_in;
   logic [ColBits-1:0]   col_count_ff, col_count_in;
   logic [HgtBits-1:0]   row_count_ff, row_count_in;
   logic [SizeBits-1:0]  pos_col_ff, pos_col_in;
   logic [SizeBits-1:0]  pos_row_ff, pos_row_in;
   logic [SizeBits-1:0]  bc_ff, bc_in, br_ff, br_in;
   logic [PosBits-1:0]   i_ff, i_in, j_ff, j_in;
   logic                 inside_ff, inside_in;
   logic [ColBits-1:0]   cb_ff, cb_in;
   logic [RowBits-1:0]   rm_ff, rm_in;
   logic [FactorBits-1:0] c_ff, c_in, r_ff, r_in;
   logic [2:0]           dbit_ff, dbit_in;
   logic                 v1_ff, v2_ff;
   logic                 issue;
   logic [WeightBits-1:0] wt_ff;
   logic [8:0]           hx, hy;
   logic [ColBits-1:0]   rd_col;
   logic [AddrBits-1:0]  rd_addr, wr_addr;
   logic                 store_we;
   logic                 req_accept;
   logic                 out_free;
   logic                 rsp_load;
   logic                 last;
   logic [SizeBits-1:0]  col0, row0, col1, row1;

   // line store
   logic [8*NumChan-1:0] line_store_ff [StoreDepth];
   logic [8*NumChan-1:0] rd_data_ff;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           out_ff [NumChan];
   logic [9:0]           bcol_ff, brow_ff;
   logic                 last_ff;

   range_type            rng_c, rng_r;
   lane_ctrl_type        lane_ctrl;
   logic [7:0]           lane_q [NumChan];
   logic [IBits-1:0]     ie, je;

   // saturated configuration
   always_comb begin
      w_sat = (width_ff == '0) ? SizeBits'(1) :
              (width_ff > SizeBits'(MaxWidth)) ? SizeBits'(MaxWidth) : width_ff;
      h_sat = (height_ff == '0) ? SizeBits'(1) :
              (height_ff > SizeBits'(MaxHeight)) ? SizeBits'(MaxHeight) : height_ff;
      f_sat = (factor_ff == '0) ? FactorBits'(1) :
              (FactorBits'(factor_ff) > FactorBits'(MaxFactor)) ? FactorBits'(MaxFactor) :
              FactorBits'(factor_ff);
   end

   always_ff @(posedge clock) begin
      nbc_ff <= div_factor(w_sat, f_sat);
      nbr_ff <= div_factor(h_sat, f_sat);
      fsq_ff <= FsqBits'(f_sat) * FsqBits'(f_sat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd64;
         height_ff <= 11'd64;
         factor_ff <= 4'd2;
         sxw_ff    <= '0;
         sxf_ff    <= '0;
         syw_ff    <= '0;
         syf_ff    <= '0;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_WIDTH:         width_ff  <= csr_data;
            CSR_HEIGHT:        height_ff <= csr_data;
            CSR_FACTOR:        factor_ff <= csr_data[3:0];
            CSR_SHIFT_X_WHOLE: sxw_ff    <= csr_data[1:0];
            CSR_SHIFT_X_FRAC:  sxf_ff    <= csr_data[7:0];
            CSR_SHIFT_Y_WHOLE: syw_ff    <= csr_data[1:0];
            CSR_SHIFT_Y_FRAC:  syf_ff    <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // position of the incoming pixel and of the next one
   always_comb begin
      col0 = req_frame_start ? '0 : SizeBits'(col_count_ff);
      row0 = req_frame_start ? '0 : SizeBits'(row_count_ff);
      if (col0 >= w_sat) begin
         col0 = '0;
         row0 = row0 + 1'b1;
      end
      if (row0 >= h_sat) begin
         row0 = '0;
      end
      col1 = col0 + 1'b1;
      row1 = row0;
      if (col1 >= w_sat) begin
         col1 = '0;
         row1 = row0 + 1'b1;
         if (row1 >= h_sat) begin
            row1 = '0;
         end
      end
      wr_addr = {mod_rows(row0), col0[ColBits-1:0]};
   end

   ssbd_trig u_trig_col (
      .clock  (clock),
      .pos    (pos_col_ff),
      .size   (w_sat),
      .factor (f_sat),
      .whole  (sxw_ff),
      .nb     (nbc_ff),
      .rng    (rng_c)
   );

   ssbd_trig u_trig_row (
      .clock  (clock),
      .pos    (pos_row_ff),
      .size   (h_sat),
      .factor (f_sat),
      .whole  (syw_ff),
      .nb     (nbr_ff),
      .rng    (rng_r)
   );

   assign req_stall  = reset || (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign last       = (bc_ff == rng_c.hi) && (br_ff == rng_r.hi);

   // window read address and bilinear weight
   always_comb begin
      rd_col  = cb_ff + ColBits'(c_ff);
      rd_addr = {rm_ff, rd_col};
      hx = (c_ff == '0) ? (9'd256 - {1'b0, sxf_ff}) :
           (c_ff == f_sat) ? {1'b0, sxf_ff} : 9'd256;
      hy = (r_ff == '0) ? (9'd256 - {1'b0, syf_ff}) :
           (r_ff == f_sat) ? {1'b0, syf_ff} : 9'd256;
      ie = IBits'(i_ff);
      je = IBits'(j_ff);
   end

   always_comb begin
      state_in     = state_ff;
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      pos_col_in   = pos_col_ff;
      pos_row_in   = pos_row_ff;
      bc_in        = bc_ff;
      br_in        = br_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      inside_in    = inside_ff;
      cb_in        = cb_ff;
      rm_in        = rm_ff;
      c_in         = c_ff;
      r_in         = r_ff;
      dbit_in      = dbit_ff;
      store_we     = 1'b0;
      issue        = 1'b0;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      lane_ctrl          = '0;
      lane_ctrl.prod_en  = v1_ff;
      lane_ctrl.acc_en   = v2_ff;
      lane_ctrl.div_bit  = dbit_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               store_we     = 1'b1;
               pos_col_in   = col0;
               pos_row_in   = row0;
               col_count_in = col1[ColBits-1:0];
               row_count_in = row1[HgtBits-1:0];
               state_in     = ST_TRIG1;
            end
         end
         ST_TRIG1: begin
            state_in = ST_TRIG2;
         end
         ST_TRIG2: begin
            if (rng_c.valid && rng_r.valid) begin
               bc_in    = rng_c.lo;
               br_in    = rng_r.lo;
               state_in = ST_BSETUP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_BSETUP: begin
            i_in     = PosBits'(bc_ff) * PosBits'(f_sat);
            j_in     = PosBits'(br_ff) * PosBits'(f_sat);
            state_in = ST_BCHECK;
         end
         ST_BCHECK: begin
            inside_in = (ie >= IBits'(sxw_ff) + 1'b1) &&
                        (ie + IBits'(sxw_ff) + 1'b1 + IBits'(f_sat) < IBits'(w_sat)) &&
                        (je >= IBits'(syw_ff) + 1'b1) &&
                        (je + IBits'(syw_ff) + 1'b1 + IBits'(f_sat) < IBits'(h_sat));
            cb_in = ColBits'(i_ff + PosBits'(sxw_ff));
            rm_in = mod_rows(SizeBits'(j_ff + PosBits'(syw_ff)));
            c_in  = '0;
            r_in  = '0;
            lane_ctrl.acc_clr = 1'b1;
            state_in = inside_in ? ST_WINDOW : ST_EMIT;
         end
         ST_WINDOW: begin
            issue = 1'b1;
            if (c_ff == f_sat) begin
               c_in  = '0;
               r_in  = r_ff + 1'b1;
               rm_in = (rm_ff == RowBits'(StoreRows - 1)) ? '0 : rm_ff + 1'b1;
               if (r_ff == f_sat) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               c_in = c_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!v1_ff && !v2_ff) begin
               lane_ctrl.div_load = 1'b1;
               dbit_in            = 3'd7;
               state_in           = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            lane_ctrl.div_step = 1'b1;
            if (dbit_ff == '0) begin
               state_in = ST_EMIT;
            end else begin
               dbit_in = dbit_ff - 1'b1;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               if (bc_ff != rng_c.hi) begin
                  bc_in    = bc_ff + 1'b1;
                  state_in = ST_BSETUP;
               end else if (br_ff != rng_r.hi) begin
                  bc_in    = rng_c.lo;
                  br_in    = br_ff + 1'b1;
                  state_in = ST_BSETUP;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_count_ff <= '0;
         row_count_ff <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
         v1_ff        <= issue;
         v2_ff        <= v1_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_col_ff <= pos_col_in;
      pos_row_ff <= pos_row_in;
      bc_ff      <= bc_in;
      br_ff      <= br_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      inside_ff  <= inside_in;
      cb_ff      <= cb_in;
      rm_ff      <= rm_in;
      c_ff       <= c_in;
      r_ff       <= r_in;
      dbit_ff    <= dbit_in;
      wt_ff      <= WeightBits'(18'(hx) * 18'(hy));
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         line_store_ff[wr_addr] <= {req_chan2, req_chan1, req_chan0};
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= line_store_ff[rd_addr];
   end

   for (genvar k = 0; k < NumChan; k++) begin : g_lane
      ssbd_lane u_lane (
         .clock  (clock),
         .ctrl   (lane_ctrl),
         .pix    (rd_data_ff[8*k +: 8]),
         .weight (wt_ff),
         .fsq    (fsq_ff),
         .quot   (lane_q[k])
      );
   end

   // merge lanes into the output register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         for (int k = 0; k < NumChan; k++) begin
            out_ff[k] <= inside_ff ? lane_q[k] : 8'd0;
         end
         bcol_ff <= bc_ff[9:0];
         brow_ff <= br_ff[9:0];
         last_ff <= last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out0      = out_ff[0];
   assign rsp_out1      = out_ff[1];
   assign rsp_out2      = out_ff[2];
   assign rsp_block_col = bcol_ff;
   assign rsp_block_row = brow_ff;
   assign rsp_run_last  = last_ff;

   a_div_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> !v1_ff && !v2_ff)
      else $error("divide started before accumulation drained");

   a_win_bounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WINDOW |-> (c_ff <= f_sat) && (r_ff <= f_sat))
      else $error("window counter out of range");

   a_row_ptr: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WINDOW |-> rm_ff < RowBits'(StoreRows - 1) || rm_ff == RowBits'(StoreRows - 1))
      else $error("line store row pointer out of range");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && out_free |=> rsp_valid_ff)
      else $error("result not loaded on emit");

endmodule

/* sv/ssbd_lane.sv */
// ----------------------------------------------------------------------------
// ssbd_lane
// One channel lane: weighted multiply-accumulate over the block window and
// a restoring divider for the rounded mean.
// ----------------------------------------------------------------------------
module ssbd_lane (
   input  logic                          clock,
   input  ssbd_pkg::lane_ctrl_type       ctrl,
   input  logic [7:0]                    pix,
   input  logic [ssbd_pkg::WeightBits-1:0] weight,
   input  logic [ssbd_pkg::FsqBits-1:0]  fsq,
   output logic [7:0]                    quot
);
   import ssbd_pkg::*;

   logic [ProdBits-1:0] prod_ff, prod_in;
   logic [AccBits-1:0]  acc_ff, acc_in;
   logic [RemBits-1:0]  rem_ff, rem_in;
   logic [RemBits-1:0]  trial;
   logic [7:0]          quot_ff, quot_in;

   always_comb begin
      prod_in = prod_ff;
      if (ctrl.prod_en) begin
         prod_in = ProdBits'(weight) * ProdBits'(pix);
      end

      acc_in = acc_ff;
      if (ctrl.acc_clr) begin
         acc_in = '0;
      end else if (ctrl.acc_en) begin
         acc_in = acc_ff + AccBits'(prod_ff);
      end

      trial   = RemBits'({fsq, 16'b0}) << ctrl.div_bit;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (ctrl.div_load) begin
         rem_in  = RemBits'(acc_ff) + RemBits'({fsq, 15'b0});
         quot_in = '0;
      end else if (ctrl.div_step && (rem_ff >= trial)) begin
         rem_in               = rem_ff - trial;
         quot_in[ctrl.div_bit] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign quot = quot_ff;

endmodule

/* sv/ssbd_trig.sv */
// ----------------------------------------------------------------------------
// ssbd_trig
// Per-axis trigger range: which blocks along one axis complete at a given
// source position. One register stage, then the range check.
// ----------------------------------------------------------------------------
module ssbd_trig (
   input  logic                            clock,
   input  logic [ssbd_pkg::SizeBits-1:0]   pos,
   input  logic [ssbd_pkg::SizeBits-1:0]   size,
   input  logic [ssbd_pkg::FactorBits-1:0] factor,
   input  logic [1:0]                      whole,
   input  logic [ssbd_pkg::SizeBits-1:0]   nb,
   output ssbd_pkg::range_type             rng
);
   import ssbd_pkg::*;

   logic [SizeBits-1:0] off;
   logic [SizeBits-1:0] xa;
   logic [SizeBits-1:0] xb;
   logic                a_ok_ff, a_ok_in;
   logic                b_case_ff, b_case_in;
   logic                b_zero_ff, b_zero_in;
   logic [SizeBits-1:0] xa_ff;
   logic [DivBits-1:0]  qa_ff, qb_ff;
   logic [PosBits-1:0]  qa_back;
   logic [SizeBits-1:0] nb_last;

   always_comb begin
      off       = SizeBits'(whole) + SizeBits'(factor);
      a_ok_in   = ((pos + 1'b1) < size) && (pos >= off);
      b_case_in = ((pos + 1'b1) == size);
      b_zero_in = ((size - 1'b1) <= off);
      xa        = pos - off;
      xb        = size - SizeBits'(2) - SizeBits'(whole);
   end

   always_ff @(posedge clock) begin
      a_ok_ff   <= a_ok_in;
      b_case_ff <= b_case_in;
      b_zero_ff <= b_zero_in;
      xa_ff     <= xa;
      qa_ff     <= div_factor(xa, factor);
      qb_ff     <= div_factor(xb, factor);
   end

   always_comb begin
      qa_back = PosBits'(qa_ff) * PosBits'(factor);
      nb_last = nb - 1'b1;
      rng     = '0;
      if (a_ok_ff) begin
         rng.lo    = qa_ff;
         rng.hi    = qa_ff;
         rng.valid = (qa_back == PosBits'(xa_ff)) && (qa_ff < nb);
      end else if (b_case_ff) begin
         rng.lo    = b_zero_ff ? '0 : qb_ff;
         rng.hi    = nb_last;
         rng.valid = (nb != '0) && (rng.lo <= nb_last);
      end
   end

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the shifted box-filter downsampler. Frames of mostly
// random pixels are sent under several register settings. A scoreboard model
// of the line store and block arithmetic predicts every block. Each result is
// compared field by field, in order; most tests idle both channels at random.
// ----------------------------------------------------------------------------
module tb;
   import ssbd_pkg::*;

   typedef struct {
      logic [7:0] out0;
      logic [7:0] out1;
      logic [7:0] out2;
      logic [9:0] block_col;
      logic [9:0] block_row;
      logic       run_last;
   } block_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_chan0;
   logic [7:0]  req_chan1;
   logic [7:0]  req_chan2;
   logic        req_frame_start;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_out0;
   logic [7:0]  rsp_out1;
   logic [7:0]  rsp_out2;
   logic [9:0]  rsp_block_col;
   logic [9:0]  rsp_block_row;
   logic        rsp_run_last;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [10:0] csr_data;

   block_type   expected_blocks[$];
   logic [23:0] pixel_store[StoreRows*MaxWidth];
   int unsigned reg_w, reg_h, reg_f, reg_wx, reg_fx, reg_wy, reg_fy;
   int unsigned next_col, next_row;
   int          error_count;
   int          idle_cycles;
   bit          busy_sides;

   subpixel_shift_box_downsample_core i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   // blocks whose clamped bottom-right coordinate is pos
   function automatic bit trigger_span(int unsigned pos, int unsigned size, int unsigned f,
                                       int unsigned w, int unsigned nb,
                                       output int unsigned lo, output int unsigned hi);
      int unsigned off;
      off = w + f;
      lo = 0;
      hi = 0;
      if (nb == 0) return 0;
      if (pos + 1 < size) begin
         if (pos < off || ((pos - off) % f) != 0) return 0;
         lo = (pos - off) / f;
         hi = lo;
         return lo < nb;
      end
      if (pos + 1 != size) return 0;
      lo = (size - 1 <= off) ? 0 : (size - 1 - off + f - 1) / f;
      hi = nb - 1;
      return lo <= hi;
   endfunction

   function automatic int unsigned stored(int unsigned row, int unsigned col, int ch);
      logic [23:0] p;
      p = pixel_store[(row % StoreRows) * MaxWidth + (col % MaxWidth)];
      return p[8*ch +: 8];
   endfunction

   function automatic void predict_blocks(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2,
                                          logic fs);
      int unsigned w, h, f, col, row, clo, chi, rlo, rhi, i, j, n, r0, c0p;
      int unsigned wt[4];
      longint unsigned acc[3];
      bit in_margin;
      block_type b;
      w = clamp_size(reg_w, MaxWidth);
      h = clamp_size(reg_h, MaxHeight);
      f = clamp_size(reg_f, MaxFactor);
      n = 0;
      col = fs ? 0 : next_col;
      row = fs ? 0 : next_row;
      if (col >= w) begin
         col = 0;
         row++;
      end
      if (row >= h) row = 0;
      pixel_store[(row % StoreRows) * MaxWidth + col] = {c2, c1, c0};
      wt[0] = (256 - reg_fx) * (256 - reg_fy);
      wt[1] = reg_fx * (256 - reg_fy);
      wt[2] = (256 - reg_fx) * reg_fy;
      wt[3] = reg_fx * reg_fy;
      if (trigger_span(col, w, f, reg_wx, w / f, clo, chi) &&
          trigger_span(row, h, f, reg_wy, h / f, rlo, rhi)) begin
         for (int unsigned br = rlo; br <= rhi; br++) begin
            for (int unsigned bc = clo; bc <= chi && n < 25; bc++) begin
               i = bc * f;
               j = br * f;
               in_margin = !(i >= reg_wx + 1 && i + reg_wx + 1 + f < w &&
                             j >= reg_wy + 1 && j + reg_wy + 1 + f < h);
               for (int ch = 0; ch < 3; ch++) begin
                  acc[ch] = 0;
                  if (!in_margin) begin
                     for (int unsigned l = 0; l < f; l++) begin
                        r0 = j + reg_wy + l;
                        for (int unsigned k = 0; k < f; k++) begin
                           c0p = i + reg_wx + k;
                           acc[ch] += longint'(wt[0]) * stored(r0, c0p, ch)
                                    + longint'(wt[1]) * stored(r0, c0p + 1, ch)
                                    + longint'(wt[2]) * stored(r0 + 1, c0p, ch)
                                    + longint'(wt[3]) * stored(r0 + 1, c0p + 1, ch);
                        end
                     end
                     acc[ch] = (acc[ch] + 32768 * f * f) / (65536 * f * f);
                  end
               end
               b.out0 = acc[0][7:0];
               b.out1 = acc[1][7:0];
               b.out2 = acc[2][7:0];
               b.block_col = bc[9:0];
               b.block_row = br[9:0];
               b.run_last = 1'b0;
               expected_blocks.insert(expected_blocks.size(), b);
               n++;
            end
         end
         if (n > 0) expected_blocks[$].run_last = 1'b1;
      end
      col++;
      if (col >= w) begin
         col = 0;
         row++;
         if (row >= h) row = 0;
      end
      next_col = col;
      next_row = row;
   endfunction

   function automatic int pick_gap();
      int r;
      if (!busy_sides) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_pixel(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2, logic fs);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_chan0 = c0;
      req_chan1 = c1;
      req_chan2 = c2;
      req_frame_start = fs;
      do @(posedge clock); while (req_stall);
      predict_blocks(c0, c1, c2, fs);
      @(negedge clock);
   endtask

   task automatic send_random(logic fs);
      send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), fs);
   endtask

   task automatic write_reg(csr_index_type idx, logic [10:0] value);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = value;
      case (idx)
         CSR_WIDTH:         reg_w  = 32'(value);
         CSR_HEIGHT:        reg_h  = 32'(value);
         CSR_FACTOR:        reg_f  = 32'(value[3:0]);
         CSR_SHIFT_X_WHOLE: reg_wx = 32'(value[1:0]);
         CSR_SHIFT_X_FRAC:  reg_fx = 32'(value[7:0]);
         CSR_SHIFT_Y_WHOLE: reg_wy = 32'(value[1:0]);
         CSR_SHIFT_Y_FRAC:  reg_fy = 32'(value[7:0]);
         default: ;
      endcase
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   task automatic wait_idle();
      req_valid = 1'b0;
      wait (expected_blocks.size() == 0);
      repeat (40) @(negedge clock);
   endtask

   task automatic configure(int w, int h, int f, int wx, int fx, int wy, int fy);
      wait_idle();
      write_reg(CSR_WIDTH, 11'(w));
      write_reg(CSR_HEIGHT, 11'(h));
      write_reg(CSR_FACTOR, 11'(f));
      write_reg(CSR_SHIFT_X_WHOLE, 11'(wx));
      write_reg(CSR_SHIFT_X_FRAC, 11'(fx));
      write_reg(CSR_SHIFT_Y_WHOLE, 11'(wy));
      write_reg(CSR_SHIFT_Y_FRAC, 11'(fy));
   endtask

   task automatic send_frame(int count);
      for (int k = 0; k < count; k++) send_random(k == 0);
   endtask

   task automatic test_directed();
      logic [7:0] v;
      busy_sides = 1'b0;
      configure(6, 6, 2, 0, 255, 0, 128);
      for (int k = 0; k < 36; k++) begin
         v = (k % 3 == 0) ? 8'd0 : (k % 3 == 1) ? 8'd255 : 8'($urandom_range(0, 255));
         send_pixel(v, ~v, 8'(k * 7), k == 0);
      end
   endtask

   task automatic test_saturation();
      busy_sides = 1'b1;
      configure(11'h7FF, 1, 15, 11'h7FF, 11'h7FF, 3, 255);
      send_frame(3);
      configure(0, 0, 0, 0, 0, 0, 0);
      for (int k = 0; k < 3; k++) send_random(1'($urandom_range(0, 1)));
   endtask

   task automatic test_corner_burst();
      busy_sides = 1'b1;
      configure(5, 5, 1, 3, $urandom_range(0, 255), 3, $urandom_range(0, 255));
      send_frame(25);
   endtask

   task automatic test_random_frames();
      int f;
      busy_sides = 1'b1;
      f = $urandom_range(1, 2);
      configure(6, 6, f, $urandom_range(0, 1), $urandom_range(0, 255),
                $urandom_range(0, 1), $urandom_range(0, 255));
      send_frame(36);
   endtask

   // stop mid-frame, then shrink the image so the position falls outside it
   task automatic test_position_wrap();
      busy_sides = 1'b1;
      configure(6, 6, 2, 0, $urandom_range(0, 255), 0, $urandom_range(0, 255));
      send_frame(22);
      configure(4, 4, 1, 0, $urandom_range(0, 255), 0, $urandom_range(0, 255));
      for (int k = 0; k < 12; k++) send_random(1'b0);
   endtask

   task automatic check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      block_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_blocks.size() == 0) begin
            $error("unexpected result col %0d row %0d", rsp_block_col, rsp_block_row);
            error_count++;
         end else begin
            e = expected_blocks.pop_front();
            check_field("out0", e.out0, rsp_out0);
            check_field("out1", e.out1, rsp_out1);
            check_field("out2", e.out2, rsp_out2);
            check_field("block_col", e.block_col, rsp_block_col);
            check_field("block_row", e.block_row, rsp_block_row);
            check_field("run_last", e.run_last, rsp_run_last);
         end
      end
   end

   initial begin
      int gap;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         gap = pick_gap();
         rsp_stall = (gap > 0);
         if (gap > 1) repeat (gap - 1) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= 20000) begin
         $display("tb: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      error_count = 0;
      idle_cycles = 0;
      busy_sides = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_chan0 = '0;
      req_chan1 = '0;
      req_chan2 = '0;
      req_frame_start = 1'b0;
      csr_write = 1'b0;
      csr_index = CSR_WIDTH;
      csr_data = '0;
      reg_w = 64;
      reg_h = 64;
      reg_f = 2;
      reg_wx = 0;
      reg_fx = 0;
      reg_wy = 0;
      reg_fy = 0;
      next_col = 0;
      next_row = 0;
      repeat (2) @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_saturation();
      test_corner_burst();
      test_random_frames();
      test_position_wrap();
      wait_idle();
      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end
endmodule

/* subpixel_shift_box_downsample_core.f */
sv/ssbd_pkg.sv
sv/ssbd_lane.sv
sv/ssbd_trig.sv
sv/subpixel_shift_box_downsample_core.sv
sim/tb.sv
